>>> rtl/i2cap_pkg.sv
// Package for the two-wire address probe master.
// Holds the phase encoding, the per-tick result bundle and shared constants.
// No dependencies.
package i2cap_pkg;

    // Width of the phase_ticks configuration word
    localparam int unsigned CFG_W = 16;

    // Default width of the interval counter
    localparam int unsigned DELAY_WIDTH_DEF = 16;

    // Reset value of phase_ticks
    localparam logic [CFG_W-1:0] PHASE_TICKS_RST = 16'd4;

    // Number of address bits shifted after the first
    localparam logic [2:0] ADDR_BITS_LAST = 3'd7;

    // Bus phases; the remaining codes of the field act as idle
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_BIT_LOW  = 4'd3,
        PH_BIT_HIGH = 4'd4,
        PH_ACK_LOW  = 4'd5,
        PH_ACK_HIGH = 4'd6,
        PH_STOP_A   = 4'd7,
        PH_STOP_B   = 4'd8,
        PH_STOP_C   = 4'd9
    } phase_t;

    // One result word
    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic done;
        logic ack;
    } tick_res_t;

endpackage

>>> rtl/i2cap_seq.sv
// Phase sequencer of the two-wire address probe master.
// Holds the phase state, the interval counter and phase_ticks; uses i2cap_pkg.
module i2cap_seq #(
    parameter int unsigned DELAY_WIDTH = i2cap_pkg::DELAY_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        begin_req,
    input  logic [6:0]                  target_address,
    input  logic                        sda_in,
    input  logic                        cfg_we,
    input  logic [i2cap_pkg::CFG_W-1:0] cfg_data,
    output i2cap_pkg::tick_res_t        res
);

    localparam int unsigned CMP_W =
        (DELAY_WIDTH > i2cap_pkg::CFG_W) ? DELAY_WIDTH : i2cap_pkg::CFG_W;

    i2cap_pkg::phase_t          phase_reg,      phase_next;
    logic [2:0]                 bits_left_reg,  bits_left_next;
    logic [7:0]                 shift_reg,      shift_next;
    logic [DELAY_WIDTH-1:0]     wait_reg,       wait_next;
    logic                       ack_reg,        ack_next;
    logic [i2cap_pkg::CFG_W-1:0] phase_ticks_reg;

    i2cap_pkg::phase_t          phase_cur;
    logic [7:0]                 shift_cur;
    logic [2:0]                 bits_cur;
    logic [DELAY_WIDTH-1:0]     wait_cur;
    logic [DELAY_WIDTH-1:0]     wait_inc;
    logic [i2cap_pkg::CFG_W-1:0] ticks;
    logic                       idle_now;
    logic                       interval_end;
    logic                       bitv;

    // Treat unused phase codes as idle
    assign idle_now = (phase_reg == i2cap_pkg::PH_IDLE) ||
                      (phase_reg > i2cap_pkg::PH_STOP_C);

    // A zero interval acts as one tick
    assign ticks = (phase_ticks_reg == '0) ? {{(i2cap_pkg::CFG_W-1){1'b0}}, 1'b1}
                                           : phase_ticks_reg;

    // Load a new probe on a request while idle
    always_comb
    begin
        if (idle_now && begin_req)
        begin
            phase_cur = i2cap_pkg::PH_START_A;
            shift_cur = {target_address, 1'b0};
            bits_cur  = i2cap_pkg::ADDR_BITS_LAST;
            wait_cur  = '0;
        end
        else
        begin
            phase_cur = idle_now ? i2cap_pkg::PH_IDLE : phase_reg;
            shift_cur = shift_reg;
            bits_cur  = bits_left_reg;
            wait_cur  = wait_reg;
        end
    end

    assign bitv     = shift_cur[7];
    assign wait_inc = wait_cur + {{(DELAY_WIDTH-1){1'b0}}, 1'b1};
    assign interval_end = (wait_inc == '0) ||
        (CMP_W'(wait_inc) >= CMP_W'(ticks));

    // Drive the lines and work out the next phase
    always_comb
    begin
        phase_next     = phase_cur;
        shift_next     = shift_cur;
        bits_left_next = bits_cur;
        wait_next      = wait_cur;
        ack_next       = ack_reg;
        res.scl        = 1'b1;
        res.sda        = 1'b1;
        res.busy       = 1'b0;
        res.done       = 1'b0;

        unique case (phase_cur)
            i2cap_pkg::PH_START_B:  begin res.scl = 1'b1; res.sda = 1'b0; end
            i2cap_pkg::PH_BIT_LOW:  begin res.scl = 1'b0; res.sda = bitv; end
            i2cap_pkg::PH_BIT_HIGH: begin res.scl = 1'b1; res.sda = bitv; end
            i2cap_pkg::PH_ACK_LOW:  begin res.scl = 1'b0; res.sda = 1'b1; end
            i2cap_pkg::PH_STOP_A:   begin res.scl = 1'b0; res.sda = 1'b0; end
            i2cap_pkg::PH_STOP_B:   begin res.scl = 1'b1; res.sda = 1'b0; end
            default:                begin res.scl = 1'b1; res.sda = 1'b1; end
        endcase

        if (phase_cur != i2cap_pkg::PH_IDLE)
        begin
            res.busy = 1'b1;
            // Sample the acknowledge on the first tick of SCL high
            if (phase_cur == i2cap_pkg::PH_ACK_HIGH && wait_cur == '0)
            begin
                ack_next = sda_in;
            end
            wait_next = wait_inc;
            if (interval_end)
            begin
                wait_next = '0;
                unique case (phase_cur)
                    i2cap_pkg::PH_START_A: phase_next = i2cap_pkg::PH_START_B;
                    i2cap_pkg::PH_START_B: phase_next = i2cap_pkg::PH_BIT_LOW;
                    i2cap_pkg::PH_BIT_LOW: phase_next = i2cap_pkg::PH_BIT_HIGH;
                    i2cap_pkg::PH_BIT_HIGH:
                    begin
                        shift_next = {shift_cur[6:0], 1'b0};
                        if (bits_cur == 3'd0)
                        begin
                            phase_next = i2cap_pkg::PH_ACK_LOW;
                        end
                        else
                        begin
                            bits_left_next = bits_cur - 3'd1;
                            phase_next     = i2cap_pkg::PH_BIT_LOW;
                        end
                    end
                    i2cap_pkg::PH_ACK_LOW:  phase_next = i2cap_pkg::PH_ACK_HIGH;
                    i2cap_pkg::PH_ACK_HIGH: phase_next = i2cap_pkg::PH_STOP_A;
                    i2cap_pkg::PH_STOP_A:   phase_next = i2cap_pkg::PH_STOP_B;
                    i2cap_pkg::PH_STOP_B:   phase_next = i2cap_pkg::PH_STOP_C;
                    default:
                    begin
                        res.done   = 1'b1;
                        phase_next = i2cap_pkg::PH_IDLE;
                    end
                endcase
            end
        end
        res.ack = ack_next;
    end

    // Advance the state once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cap_pkg::PH_IDLE;
            bits_left_reg <= '0;
            shift_reg     <= '0;
            wait_reg      <= '0;
            ack_reg       <= 1'b1;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            bits_left_reg <= bits_left_next;
            shift_reg     <= shift_next;
            wait_reg      <= wait_next;
            ack_reg       <= ack_next;
        end
    end

    // Hold the interval length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2cap_pkg::PHASE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            phase_ticks_reg <= cfg_data;
        end
    end

    // A finished probe always returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done |=> phase_reg == i2cap_pkg::PH_IDLE)
        else $error("probe did not return to idle after done");

    // Both lines are released whenever no probe runs
    a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        !res.busy |-> res.scl && res.sda)
        else $error("line driven while idle");

    // The interval counter rests at zero while no probe runs
    a_wait_idle: assert property (@(posedge clk) disable iff (!rst_n)
        idle_now |-> wait_reg == '0)
        else $error("interval counter running while idle");

    // The acknowledge latch only moves in the acknowledge high phase
    a_ack_phase: assert property (@(posedge clk) disable iff (!rst_n)
        step && (ack_next != ack_reg) |-> phase_cur == i2cap_pkg::PH_ACK_HIGH)
        else $error("acknowledge latched outside its phase");

endmodule

>>> rtl/i2c_address_probe_master_core.sv
// A result word is registered and appears in the cycle after its input tick is accepted.
// Throughput: one tick per cycle; the output register is refilled in the
// cycle it is taken, so in_ready only drops while a result waits unclaimed.
// Reset (rst_n, asynchronous, active low): sequencer idle, ack latch 1,
// phase_ticks 4, out_valid low, res_reg not reset. The configuration port is always ready.
// Top level of the two-wire address probe master; uses i2cap_pkg, i2cap_seq.
module i2c_address_probe_master_core #(
    parameter int unsigned DELAY_WIDTH = i2cap_pkg::DELAY_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        begin_req,
    input  logic [6:0]                  target_address,
    input  logic                        sda_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        scl_out,
    output logic                        sda_out,
    output logic                        busy_res,
    output logic                        done_res,
    output logic                        ack_level,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [i2cap_pkg::CFG_W-1:0] phase_ticks
);

    logic                 out_valid_reg;
    i2cap_pkg::tick_res_t res_reg;
    i2cap_pkg::tick_res_t res_comb;
    logic                 step;

    // Take a new word whenever the output register is free or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    i2cap_seq #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .begin_req      (begin_req),
        .target_address (target_address),
        .sda_in         (sda_in),
        .cfg_we         (cfg_valid),
        .cfg_data       (phase_ticks),
        .res            (res_comb)
    );

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_out   = res_reg.scl;
    assign sda_out   = res_reg.sda;
    assign busy_res  = res_reg.busy;
    assign done_res  = res_reg.done;
    assign ack_level = res_reg.ack;

    // A waiting result never blocks past the cycle it is taken
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg || out_ready |-> in_ready)
        else $error("input stalled with free output register");

    // An accepted word is always shown in the next cycle
    a_step_shown: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("accepted word not presented");

    // A done word always reports busy too
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.done |-> res_reg.busy)
        else $error("done without busy");

endmodule
